// File: rtl/core/efb_pkg.sv
// ----------------------------------------------------------------------------
// efb_pkg: shared definitions for the escaped frame builder
// Line byte codes, the escape map and the token bundle handed to the emitter.
// ----------------------------------------------------------------------------
package efb_pkg;

    localparam logic [7:0] HEAD_BYTE    = 8'hDB;
    localparam logic [7:0] TAIL_BYTE    = 8'hDE;
    localparam logic [7:0] ESC_BYTE     = 8'hDC;
    localparam logic [7:0] ESC_HEAD     = 8'hCB;
    localparam logic [7:0] ESC_TAIL     = 8'hCE;
    localparam logic [7:0] ESC_ESC      = 8'hCC;
    localparam logic [7:0] VERSION_BYTE = 8'h01;

    // Head, four header bytes, one payload byte, checksum and tail.
    localparam int TokMax  = 8;
    localparam int TokIdxW = $clog2(TokMax);

    // Unescaped bytes that one request turns into, in line order.
    typedef struct packed {
        logic [TokMax-1:0][7:0] byte_list;
        logic [TokMax-1:0]      esc_mask;   // 1 where the byte goes through escaping
        logic [TokIdxW-1:0]     last_idx;   // position of the final byte
        logic                   closes;     // final byte is the tail
    } token_bundle_t;

    function automatic logic is_special(input logic [7:0] b);
        return (b == HEAD_BYTE) || (b == TAIL_BYTE) || (b == ESC_BYTE);
    endfunction

    // Second byte of an escape pair; only meaningful for special bytes.
    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] code;
        unique case (b)
            HEAD_BYTE: code = ESC_HEAD;
            TAIL_BYTE: code = ESC_TAIL;
            default:   code = ESC_ESC;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/efb_emitter.sv
// ----------------------------------------------------------------------------
// efb_emitter: byte serializer with escaping
// Holds one token bundle and sends it out one line byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module efb_emitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    output logic                   load_ready,
    input  efb_pkg::token_bundle_t load_bundle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output logic                   out_end
);

    efb_pkg::token_bundle_t       slot_reg;
    logic                         slot_valid_reg;
    logic [efb_pkg::TokIdxW-1:0]  idx_reg;
    logic                         half_reg;

    logic [7:0] cur_byte;
    logic       special;
    logic       tok_done;
    logic       fire;
    logic       load_fire;

    always_comb
    begin
        cur_byte = slot_reg.byte_list[idx_reg];
        special  = slot_reg.esc_mask[idx_reg] && efb_pkg::is_special(cur_byte);
        tok_done = !special || half_reg;
        out_last = tok_done && (idx_reg == slot_reg.last_idx);
        out_end  = out_last && slot_reg.closes;
        if (special)
        begin
            out_byte = half_reg ? efb_pkg::esc_code(cur_byte) : efb_pkg::ESC_BYTE;
        end
        else
        begin
            out_byte = cur_byte;
        end
    end

    assign out_valid  = slot_valid_reg;
    assign fire       = slot_valid_reg && out_ready;
    assign load_ready = !slot_valid_reg || (fire && out_last);
    assign load_fire  = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            idx_reg        <= '0;
            half_reg       <= 1'b0;
        end
        else if (load_fire)
        begin
            slot_valid_reg <= 1'b1;
            idx_reg        <= '0;
            half_reg       <= 1'b0;
        end
        else if (fire)
        begin
            if (out_last)
            begin
                slot_valid_reg <= 1'b0;
                idx_reg        <= '0;
                half_reg       <= 1'b0;
            end
            else if (tok_done)
            begin
                idx_reg  <= idx_reg + 1'b1;
                half_reg <= 1'b0;
            end
            else
            begin
                half_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            slot_reg <= load_bundle;
        end
    end

endmodule

// File: rtl/core/escaped_frame_builder.sv
// ----------------------------------------------------------------------------
// escaped_frame_builder: byte-stuffed serial framer with XOR checksum
// Turns command and payload requests into an escaped line byte stream.
// ----------------------------------------------------------------------------
// A request is registered in the pending stage, then loaded into the emitter.
// A request turns into 1 to 10 line bytes, a plain mid-frame payload byte into
// one and an escaped one into two; the emitter sends one byte per cycle while
// m_axis_tready is high, and a new request can wait in the pending stage.
// Reset: rst_n clears the frame state and all valid flags at once; no
// clearing pass is needed and the first request may follow right after reset.
// ----------------------------------------------------------------------------
module escaped_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] command_code, [23:8] payload_length, [31:24] payload_byte
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] line_byte
    output logic [7:0]  m_axis_tdata,
    // last_of_run
    output logic        m_axis_tlast,
    // [0] frame_end
    output logic        m_axis_tuser
);

    // Frame state, updated at the edge where a request is accepted.
    logic        in_frame_reg,    in_frame_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [15:0] bytes_left_reg,  bytes_left_next;

    // Pending stage: a request already turned into its byte list, waiting for
    // the emitter. It lets a new request in while the emitter still drains.
    efb_pkg::token_bundle_t pend_reg, pend_next;
    logic                   pend_valid_reg;

    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [15:0] frame_len;
    logic [7:0]  xor_new;
    logic        closes;
    logic        accept;
    logic        emit_ready;
    logic        pend_move;

    assign command_code   = s_axis_tdata[7:0];
    assign payload_length = s_axis_tdata[23:8];
    assign payload_byte   = s_axis_tdata[31:24];
    assign frame_len      = payload_length + 16'd3;

    assign pend_move     = pend_valid_reg && emit_ready;
    assign s_axis_tready = !pend_valid_reg || pend_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Checksum, close decision and byte list for the incoming request.
    always_comb
    begin
        pend_next = '0;
        if (!in_frame_reg)
        begin
            // Opening request: head, length low and high, version, command.
            xor_new = frame_len[7:0] ^ frame_len[15:8] ^ efb_pkg::VERSION_BYTE
                    ^ command_code ^ ((payload_length != 16'd0) ? payload_byte : 8'h00);
            closes  = (payload_length == 16'd0) || (payload_length == 16'd1);
            pend_next.byte_list[0] = efb_pkg::HEAD_BYTE;
            pend_next.byte_list[1] = frame_len[7:0];
            pend_next.byte_list[2] = frame_len[15:8];
            pend_next.byte_list[3] = efb_pkg::VERSION_BYTE;
            pend_next.byte_list[4] = command_code;
            pend_next.esc_mask[4:1] = 4'b1111;
            if (payload_length == 16'd0)
            begin
                // Header-only frame goes straight to checksum and tail.
                pend_next.byte_list[5] = xor_new;
                pend_next.byte_list[6] = efb_pkg::TAIL_BYTE;
                pend_next.esc_mask[5]  = 1'b1;
                pend_next.last_idx     = efb_pkg::TokIdxW'(6);
            end
            else
            begin
                pend_next.byte_list[5] = payload_byte;
                pend_next.esc_mask[5]  = 1'b1;
                if (closes)
                begin
                    pend_next.byte_list[6] = xor_new;
                    pend_next.byte_list[7] = efb_pkg::TAIL_BYTE;
                    pend_next.esc_mask[6]  = 1'b1;
                    pend_next.last_idx     = efb_pkg::TokIdxW'(7);
                end
                else
                begin
                    pend_next.last_idx = efb_pkg::TokIdxW'(5);
                end
            end
        end
        else
        begin
            xor_new = running_xor_reg ^ payload_byte;
            closes  = (bytes_left_reg <= 16'd1);
            pend_next.byte_list[0] = payload_byte;
            pend_next.esc_mask[0]  = 1'b1;
            if (closes)
            begin
                pend_next.byte_list[1] = xor_new;
                pend_next.byte_list[2] = efb_pkg::TAIL_BYTE;
                pend_next.esc_mask[1]  = 1'b1;
                pend_next.last_idx     = efb_pkg::TokIdxW'(2);
            end
            else
            begin
                pend_next.last_idx = '0;
            end
        end
        pend_next.closes = closes;

        if (closes)
        begin
            in_frame_next    = 1'b0;
            running_xor_next = 8'h00;
            bytes_left_next  = 16'd0;
        end
        else
        begin
            in_frame_next    = 1'b1;
            running_xor_next = xor_new;
            bytes_left_next  = in_frame_reg ? (bytes_left_reg - 16'd1)
                                            : (payload_length - 16'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            running_xor_reg <= 8'h00;
            bytes_left_reg  <= 16'd0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_frame_reg    <= in_frame_next;
                running_xor_reg <= running_xor_next;
                bytes_left_reg  <= bytes_left_next;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    // The emitter walks the byte list and inserts escape pairs on the fly.
    efb_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (pend_valid_reg),
        .load_ready  (emit_ready),
        .load_bundle (pend_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_last    (m_axis_tlast),
        .out_end     (m_axis_tuser)
    );

    // The tail byte is always the final byte of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end flagged on a byte that is not last of its request");

    // An open frame always has payload bytes still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != 16'd0))
        else $error("frame open with no payload bytes left");

    // Between frames the checksum accumulator is clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (running_xor_reg == 8'h00))
        else $error("checksum not cleared between frames");

    // A pending request the emitter cannot take yet stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !emit_ready |=> pend_valid_reg && $stable(pend_reg))
        else $error("pending request lost or changed while the emitter was busy");

endmodule

// File: test/tb_escaped_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_builder: self-checking bench for the escaped frame builder
// Sends command and payload requests through the slave stream and compares
// every line byte against typed lines or a behavioral frame predictor. A short table of
// directed frames comes first, then random frames with random stalls on both
// sides, and finally a quiet phase that ends by opening one maximum-count
// frame whose length field wraps.
// ----------------------------------------------------------------------------
module tb_escaped_frame_builder;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 280;
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 17;

    // One line byte as it leaves on the master stream.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_run;
        logic       frame_end;
    } line_beat_t;

    // One directed request. Where typed_count is not zero, typed_bytes holds
    // the whole expected line, first byte leftmost; the final byte is the tail.
    typedef struct packed {
        logic [7:0]   command_code;
        logic [15:0]  payload_length;
        logic [7:0]   payload_byte;
        logic [3:0]   typed_count;
        logic [111:0] typed_bytes;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] command_code, [23:8] payload_length, [31:24] payload_byte
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] line_byte
    logic [7:0]  m_axis_tdata;
    // last_of_run
    logic        m_axis_tlast;
    // [0] frame_end
    logic        m_axis_tuser;

    escaped_frame_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: open frame flag, running XOR and payload bytes to come.
    bit           frame_open;
    logic [7:0]   xor_sum;
    logic [15:0]  payload_left;

    line_beat_t   request_bytes[$];   // line bytes of the request being predicted
    line_beat_t   line_expect[$];     // line bytes still owed by the block

    request_row_t directed_rows [DIR_ROWS];
    line_beat_t   got_beat;
    line_beat_t   want_beat;
    int           idle_odds;          // 0: no stalls, else a stall starts 1 time in idle_odds
    int           errors;
    int           cycles;
    int           random_items;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------------
    function automatic void put_raw(input logic [7:0] b);
        line_beat_t beat;
        beat.line_byte   = b;
        beat.last_of_run = 1'b0;
        beat.frame_end   = 1'b0;
        request_bytes.push_back(beat);
    endfunction

    function automatic void put_escaped(input logic [7:0] b);
        case (b)
            efb_pkg::HEAD_BYTE:
            begin
                put_raw(efb_pkg::ESC_BYTE);
                put_raw(efb_pkg::ESC_HEAD);
            end
            efb_pkg::TAIL_BYTE:
            begin
                put_raw(efb_pkg::ESC_BYTE);
                put_raw(efb_pkg::ESC_TAIL);
            end
            efb_pkg::ESC_BYTE:
            begin
                put_raw(efb_pkg::ESC_BYTE);
                put_raw(efb_pkg::ESC_ESC);
            end
            default: put_raw(b);
        endcase
    endfunction

    // Header and payload bytes count toward the checksum; the head byte does not.
    function automatic void put_summed(input logic [7:0] b);
        xor_sum = xor_sum ^ b;
        put_escaped(b);
    endfunction

    function automatic void finish_frame();
        line_beat_t beat;
        put_escaped(xor_sum);
        put_raw(efb_pkg::TAIL_BYTE);
        beat = request_bytes.pop_back();
        beat.frame_end = 1'b1;
        request_bytes.push_back(beat);
        frame_open   = 1'b0;
        xor_sum      = 8'h00;
        payload_left = 16'd0;
    endfunction

    // Fills request_bytes with the line bytes that one accepted request causes.
    function automatic void predict_line(input logic [7:0] cmd, input logic [15:0] plen,
                                         input logic [7:0] pbyte);
        logic [15:0] len_field;
        line_beat_t  beat;
        request_bytes.delete();
        if (!frame_open)
        begin
            // The length field wraps at 16 bits for out-of-range counts.
            len_field = plen + 16'd3;
            xor_sum   = 8'h00;
            put_raw(efb_pkg::HEAD_BYTE);
            put_summed(len_field[7:0]);
            put_summed(len_field[15:8]);
            put_summed(efb_pkg::VERSION_BYTE);
            put_summed(cmd);
            if (plen == 16'd0)
                finish_frame();
            else
            begin
                put_summed(pbyte);
                payload_left = plen - 16'd1;
                frame_open   = 1'b1;
                if (payload_left == 16'd0)
                    finish_frame();
            end
        end
        else
        begin
            // Command and length are ignored while a frame is open.
            put_summed(pbyte);
            if (payload_left != 16'd0)
                payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0)
                finish_frame();
        end
        beat = request_bytes.pop_back();
        beat.last_of_run = 1'b1;
        request_bytes.push_back(beat);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Presents one request and returns at the edge where it is taken. The
    // ready is sampled at the falling edge, where it is settled, so the
    // handshake is known without racing the block's own update.
    task automatic send_request(input logic [7:0] cmd, input logic [15:0] plen,
                                input logic [7:0] pbyte, input request_row_t row,
                                input bit use_typed);
        bit         took;
        line_beat_t beat;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pbyte, plen, cmd};
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);

        predict_line(cmd, plen, pbyte);
        if (use_typed)
        begin
            for (int i = 0; i < row.typed_count; i++)
            begin
                beat.line_byte   = row.typed_bytes[(row.typed_count - 1 - i) * 8 +: 8];
                beat.last_of_run = (i == row.typed_count - 1);
                beat.frame_end   = (i == row.typed_count - 1);
                line_expect.push_back(beat);
            end
        end
        else
        begin
            foreach (request_bytes[i])
                line_expect.push_back(request_bytes[i]);
        end
    endtask

    // Bytes lean toward the three special codes so escaping is hit often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return efb_pkg::HEAD_BYTE;
            1:       return efb_pkg::TAIL_BYTE;
            2:       return efb_pkg::ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One complete frame; mid-frame requests carry random command and length
    // fields, which the block must ignore.
    task automatic send_random_frame(input logic [15:0] plen);
        request_row_t unused_row;
        unused_row = '0;
        send_request(pick_byte(), plen, pick_byte(), unused_row, 1'b0);
        random_items++;
        for (int i = 1; i < plen; i++)
        begin
            send_request(8'($urandom), 16'($urandom), pick_byte(), unused_row, 1'b0);
            random_items++;
        end
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return 16'($urandom_range(0, 4));
        else if (r < 19)
            return 16'($urandom_range(5, 24));
        else
            return 16'($urandom_range(25, 60));
    endfunction

    // ------------------------------------------------------------------------
    // Line byte checker
    // ------------------------------------------------------------------------
    // A byte shown with valid and ready at the falling edge is taken at the
    // next rising edge, since ready only moves at rising edges.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beat.line_byte   = m_axis_tdata;
            got_beat.last_of_run = m_axis_tlast;
            got_beat.frame_end   = m_axis_tuser;
            if (line_expect.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: line byte %h last %b end %b arrived with none expected",
                             $realtime, got_beat.line_byte, got_beat.last_of_run,
                             got_beat.frame_end);
            end
            else
            begin
                want_beat = line_expect.pop_front();
                if (got_beat !== want_beat)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: expected byte %h last %b end %b, got byte %h last %b end %b",
                                 $realtime, want_beat.line_byte, want_beat.last_of_run,
                                 want_beat.frame_end, got_beat.line_byte,
                                 got_beat.last_of_run, got_beat.frame_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready drops in random bursts while idle_odds allows it.
    // ------------------------------------------------------------------------
    initial
    begin : line_sink
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                hold = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        request_row_t unused_row;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        frame_open    = 1'b0;
        xor_sum       = 8'h00;
        payload_left  = 16'd0;
        idle_odds     = 4;
        errors        = 0;
        random_items  = 0;
        unused_row    = '0;

        // Zero-length frames with typed lines: plain, all ones, and a command
        // equal to each special code (the last two also escape the checksum).
        directed_rows[0]  = '{8'h00, 16'd0, 8'h00, 4'd7, 112'hDB_03_00_01_00_02_DE};
        directed_rows[1]  = '{8'hFF, 16'd0, 8'hFF, 4'd7, 112'hDB_03_00_01_FF_FD_DE};
        directed_rows[2]  = '{efb_pkg::HEAD_BYTE, 16'd0, efb_pkg::HEAD_BYTE, 4'd8,
                              112'hDB_03_00_01_DC_CB_D9_DE};
        directed_rows[3]  = '{efb_pkg::TAIL_BYTE, 16'd0, efb_pkg::TAIL_BYTE, 4'd9,
                              112'hDB_03_00_01_DC_CE_DC_CC_DE};
        directed_rows[4]  = '{efb_pkg::ESC_BYTE, 16'd0, efb_pkg::ESC_BYTE, 4'd9,
                              112'hDB_03_00_01_DC_CC_DC_CE_DE};
        // Single-byte frames, one with escaped command and payload.
        directed_rows[5]  = '{efb_pkg::ESC_BYTE, 16'd1, efb_pkg::TAIL_BYTE, 4'd0, 112'd0};
        directed_rows[6]  = '{8'h01, 16'd1, 8'h00, 4'd0, 112'd0};
        // Two-byte frame; the closing request carries an all-ones length.
        directed_rows[7]  = '{8'h5A, 16'd2, efb_pkg::HEAD_BYTE, 4'd0, 112'd0};
        directed_rows[8]  = '{8'hFF, 16'hFFFF, efb_pkg::ESC_BYTE, 4'd0, 112'd0};
        // Three-byte frame; a mid-frame zero length must not close it early.
        directed_rows[9]  = '{8'hA5, 16'd3, 8'h00, 4'd0, 112'd0};
        directed_rows[10] = '{8'h00, 16'd0, 8'hFF, 4'd0, 112'd0};
        directed_rows[11] = '{efb_pkg::TAIL_BYTE, 16'd5, 8'hFF, 4'd0, 112'd0};
        // Four-byte frame; its first three payload bytes are special.
        directed_rows[12] = '{8'h7E, 16'd4, efb_pkg::TAIL_BYTE, 4'd0, 112'd0};
        directed_rows[13] = '{8'h00, 16'd0, efb_pkg::ESC_BYTE, 4'd0, 112'd0};
        directed_rows[14] = '{8'h11, 16'd1, efb_pkg::HEAD_BYTE, 4'd0, 112'd0};
        directed_rows[15] = '{8'h22, 16'd2, 8'h80, 4'd0, 112'd0};
        // Zero-length frame directly after a closed one.
        directed_rows[16] = '{8'h3C, 16'd0, 8'h55, 4'd0, 112'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].command_code, directed_rows[i].payload_length,
                         directed_rows[i].payload_byte, directed_rows[i],
                         directed_rows[i].typed_count != 4'd0);

        // Random frames; each frame picks its own stall rate, sometimes none.
        while (random_items < RANDOM_ITEMS)
        begin
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
            send_random_frame(pick_length());
        end

        // Quiet phase: no stalls, a few short frames, then a frame with the
        // largest count, whose length field wraps to two. That frame stays
        // open; only its first few payload bytes are sent.
        idle_odds = 0;
        repeat (4) send_random_frame(pick_length());
        send_request(pick_byte(), 16'hFFFF, pick_byte(), unused_row, 1'b0);
        repeat (6)
            send_request(8'($urandom), 16'($urandom), pick_byte(), unused_row, 1'b0);
        s_axis_tvalid <= 1'b0;

        while (line_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/core/efb_pkg.sv
rtl/core/efb_emitter.sv
rtl/core/escaped_frame_builder.sv
test/tb_escaped_frame_builder.sv
